>>> hdl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int IDX_W      = 11;
    localparam int CELL_W     = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    localparam logic REQ_PUT   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [IDX_W-1:0] SCROLL_IDX = IDX_W'((ROWS - 1) * COLUMNS);
    localparam logic [IDX_W-1:0] COPY_END   = IDX_W'(CELLS - COLUMNS);
    localparam logic [IDX_W-1:0] FILL_END   = IDX_W'(CELLS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_FILL
    } t_state;

    typedef struct packed {
        logic accept;
        logic walk_clr;
        logic walk_inc;
        logic copy;
        logic fill;
        logic out_set;
    } t_ctrl_cmd;

    typedef struct packed {
        logic req_clear;
        logic need_scroll;
        logic copy_last;
        logic fill_last;
        logic out_busy;
    } t_dp_status;

endpackage

>>> hdl/tcw_ctrl.sv
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_out_ready,
    input  tcw_pkg::t_dp_status i_status,
    output logic               o_ready,
    output tcw_pkg::t_ctrl_cmd o_cmd
);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;
    logic            take;

    assign o_ready = (r_state == tcw_pkg::S_IDLE) && (!i_status.out_busy || i_out_ready);
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (take && i_status.req_clear) begin
                    n_state = tcw_pkg::S_FILL;
                end else if (take && i_status.need_scroll) begin
                    n_state = tcw_pkg::S_COPY;
                end
            end
            tcw_pkg::S_COPY: begin
                if (i_status.copy_last) begin
                    n_state = tcw_pkg::S_FILL;
                end
            end
            tcw_pkg::S_FILL: begin
                if (i_status.fill_last) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                o_cmd.accept   = take;
                o_cmd.walk_clr = take;
                o_cmd.out_set  = take && !i_status.req_clear && !i_status.need_scroll;
            end
            tcw_pkg::S_COPY: begin
                o_cmd.copy     = 1'b1;
                o_cmd.walk_inc = !i_status.copy_last;
            end
            tcw_pkg::S_FILL: begin
                o_cmd.fill     = 1'b1;
                o_cmd.walk_inc = !i_status.fill_last;
                o_cmd.out_set  = i_status.fill_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hdl/tcw_dp.sv
module tcw_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcw_pkg::t_ctrl_cmd               i_cmd,
    output tcw_pkg::t_dp_status              o_status,
    input  logic                             i_cfg_wr_en,
    input  logic [7:0]                       i_cfg_wr_data,
    input  logic                             i_req_type,
    input  logic [7:0]                       i_char_code,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [tcw_pkg::IDX_W-1:0]        o_cursor_index,
    output logic [tcw_pkg::COL_W-1:0]        o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]        o_cursor_row,
    output logic                             o_did_scroll
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    logic [7:0]                 r_attr;
    logic [tcw_pkg::COL_W-1:0]  r_col;
    logic [tcw_pkg::ROW_W-1:0]  r_row;
    logic [tcw_pkg::IDX_W-1:0]  r_idx;
    logic                       r_scroll;
    logic [tcw_pkg::IDX_W-1:0]  r_walk;
    logic                       r_out_valid;

    logic [tcw_pkg::COL_W-1:0]  n_col;
    logic [tcw_pkg::ROW_W-1:0]  n_row;
    logic [tcw_pkg::IDX_W-1:0]  n_idx;
    logic                       n_scroll;

    logic                       is_clear;
    logic                       is_newline;
    logic                       next_line;

    logic                       wr_en;
    logic [tcw_pkg::IDX_W-1:0]  wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;
    logic                       rd_en;
    logic [tcw_pkg::IDX_W-1:0]  rd_addr;

    assign is_clear   = (i_req_type == tcw_pkg::REQ_CLEAR);
    assign is_newline = (i_char_code == tcw_pkg::NEWLINE_CODE);
    assign next_line  = is_newline || (r_col == tcw_pkg::LAST_COL);

    assign o_status.req_clear   = is_clear;
    assign o_status.need_scroll = !is_clear && next_line && (r_row == tcw_pkg::LAST_ROW);
    assign o_status.copy_last   = (r_walk == tcw_pkg::COPY_END);
    assign o_status.fill_last   = (r_walk == tcw_pkg::FILL_END);
    assign o_status.out_busy    = r_out_valid;

    // cursor after the request
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_idx    = r_idx;
        n_scroll = 1'b0;
        if (is_clear) begin
            n_col = '0;
            n_row = '0;
            n_idx = '0;
        end else if (next_line) begin
            n_col = '0;
            if (r_row == tcw_pkg::LAST_ROW) begin
                n_idx    = tcw_pkg::SCROLL_IDX;
                n_scroll = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
                n_idx = r_idx - tcw_pkg::IDX_W'(r_col) + tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
            end
        end else begin
            n_col = r_col + 1'b1;
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= tcw_pkg::ATTR_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_idx       <= '0;
            r_scroll    <= 1'b0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_idx    <= n_idx;
                r_scroll <= n_scroll;
            end
            if (i_cmd.walk_clr) begin
                r_walk <= is_clear ? '0 : '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + 1'b1;
            end
            r_out_valid <= (r_out_valid && !i_out_ready) || i_cmd.out_set;
        end
    end

    // screen store port muxing: put, scroll copy (read ahead one row), blank fill
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = {r_attr, i_char_code};
        rd_en   = i_cmd.copy && (r_walk != tcw_pkg::COPY_END);
        rd_addr = r_walk + tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
        if (i_cmd.accept) begin
            wr_en = !is_clear && !is_newline;
        end else if (i_cmd.copy) begin
            wr_en   = (r_walk != '0);
            wr_addr = r_walk - 1'b1;
            wr_data = r_rd_data;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_addr = r_walk;
            wr_data = {r_attr, tcw_pkg::BLANK_CODE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_index = r_idx;
    assign o_cursor_col   = r_col;
    assign o_cursor_row   = r_row;
    assign o_did_scroll   = r_scroll;

endmodule

>>> hdl/text_console_writer.sv
// Text console writer: an 80x25 text screen store of 16-bit cells (attribute
// byte over character byte) with a cursor. A put writes the character with the
// current attribute at the cursor and advances it; code 10 is a newline and is
// not stored. Leaving the bottom row scrolls the screen up one row and blanks
// the last row; a clear request blanks the screen and homes the cursor. Each
// request returns the cursor index, column, row and a scroll flag. A put or
// newline that does not scroll needs no walk, so these go in one per cycle while
// results are taken. The store has one write port, which sets the cost of the
// walks: a scroll makes 1921 copy steps, reading one row ahead, then 80
// blanking steps; a clear makes 2000 blanking steps. No request is taken
// during a walk; attribute writes are taken at any time but belong to idle
// periods. Store contents are undefined until written.
module text_console_writer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [7:0]                i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req_type,
    input  logic [7:0]                i_char_code,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [tcw_pkg::IDX_W-1:0] o_cursor_index,
    output logic [tcw_pkg::COL_W-1:0] o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0] o_cursor_row,
    output logic                      o_did_scroll
);

    tcw_pkg::t_ctrl_cmd  cmd;
    tcw_pkg::t_dp_status status;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    tcw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_req_type     (i_req_type),
        .i_char_code    (i_char_code),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_cursor_index (o_cursor_index),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_did_scroll   (o_did_scroll)
    );

endmodule

>>> hdl/tcw_checker.sv
module tcw_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      i_req_type,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [tcw_pkg::IDX_W-1:0] o_cursor_index,
    input logic [tcw_pkg::COL_W-1:0] o_cursor_col,
    input logic [tcw_pkg::ROW_W-1:0] o_cursor_row,
    input logic                      o_did_scroll
);

    logic [tcw_pkg::IDX_W-1:0] lin_idx;

    assign lin_idx = tcw_pkg::IDX_W'(o_cursor_row) * tcw_pkg::IDX_W'(tcw_pkg::COLUMNS)
                   + tcw_pkg::IDX_W'(o_cursor_col);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_index) && $stable(o_did_scroll))
        else $error("result changed while stalled");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_index == lin_idx) && (o_cursor_col <= tcw_pkg::LAST_COL)
                    && (o_cursor_row <= tcw_pkg::LAST_ROW))
        else $error("cursor index does not match column and row");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_did_scroll |-> (o_cursor_row == tcw_pkg::LAST_ROW) && (o_cursor_col == '0))
        else $error("scroll left cursor off the bottom row start");

    a_clear_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_req_type == tcw_pkg::REQ_CLEAR) |=> !o_valid && !o_ready)
        else $error("clear did not stall for the blanking walk");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_req_type     (i_req_type),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_cursor_index (o_cursor_index),
    .o_cursor_col   (o_cursor_col),
    .o_cursor_row   (o_cursor_row),
    .o_did_scroll   (o_did_scroll)
);

>>> tb/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;

    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 240;

    typedef struct packed {
        logic [tcw_pkg::IDX_W-1:0] index;
        logic [tcw_pkg::COL_W-1:0] col;
        logic [tcw_pkg::ROW_W-1:0] row;
        logic                      scrolled;
    } t_cursor;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [7:0]                i_cfg_wr_data;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_req_type;
    logic [7:0]                i_char_code;
    logic                      o_valid;
    logic                      i_ready;
    logic [tcw_pkg::IDX_W-1:0] o_cursor_index;
    logic [tcw_pkg::COL_W-1:0] o_cursor_col;
    logic [tcw_pkg::ROW_W-1:0] o_cursor_row;
    logic                      o_did_scroll;

    t_cursor     cursor_expect_q[$];
    int unsigned col_now;
    int unsigned row_now;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned rx_hold;
    int unsigned rx_draw;
    int          err_count;
    int          results_checked;
    int          items_sent;
    int          scrolls_predicted;
    int          clears_sent;
    int          cycle_count = 0;

    text_console_writer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cursor_index (o_cursor_index),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_did_scroll   (o_did_scroll)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, cursor_expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // cursor predictor: store contents never reach the outputs
    task automatic predict_cursor(input logic req, input logic [7:0] ch);
        t_cursor r;
        r.scrolled = 1'b0;
        if (req == tcw_pkg::REQ_CLEAR) begin
            col_now = 0;
            row_now = 0;
            clears_sent++;
        end else begin
            if (ch != tcw_pkg::NEWLINE_CODE)
                col_now++;
            if (ch == tcw_pkg::NEWLINE_CODE || col_now >= tcw_pkg::COLUMNS) begin
                col_now = 0;
                if (row_now + 1 >= tcw_pkg::ROWS)
                    r.scrolled = 1'b1;
                else
                    row_now++;
            end
        end
        r.index = tcw_pkg::IDX_W'(row_now * tcw_pkg::COLUMNS + col_now);
        r.col   = tcw_pkg::COL_W'(col_now);
        r.row   = tcw_pkg::ROW_W'(row_now);
        if (r.scrolled)
            scrolls_predicted++;
        cursor_expect_q.push_back(r);
    endtask

    task automatic check_cursor_result();
        t_cursor got;
        t_cursor want;
        got = {o_cursor_index, o_cursor_col, o_cursor_row, o_did_scroll};
        if (cursor_expect_q.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_MAX)
                $display("unexpected result: idx %0d col %0d row %0d scroll %0b",
                         got.index, got.col, got.row, got.scrolled);
        end else begin
            want = cursor_expect_q.pop_front();
            results_checked++;
            if (got !== want) begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("mismatch idx/col/row/scr exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             want.index, want.col, want.row, want.scrolled,
                             got.index, got.col, got.row, got.scrolled);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else if (o_valid && i_ready) begin
            check_cursor_result();
            rx_draw = rx_idle_on ? $urandom_range(0, 19) : 0;
            rx_hold <= rx_draw;
            i_ready <= (rx_draw == 0);
        end else if (!i_ready) begin
            if (rx_hold <= 1) begin
                i_ready <= 1'b1;
                rx_hold <= 0;
            end else begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == tcw_pkg::NEWLINE_CODE);
        return c;
    endfunction

    task automatic send_request(input logic req, input logic [7:0] ch);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_char_code <= ch;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        predict_cursor(req, ch);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (cursor_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_text_attribute(input logic [7:0] attr);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= attr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // clear first so that no later scroll reads an unwritten cell
    task automatic test_edge_codes();
        send_request(tcw_pkg::REQ_CLEAR, 8'hFF);
        send_request(tcw_pkg::REQ_PUT, 8'h00);
        send_request(tcw_pkg::REQ_PUT, 8'hFF);
        send_request(tcw_pkg::REQ_PUT, 8'h0D);
        send_request(tcw_pkg::REQ_PUT, 8'h09);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::BLANK_CODE);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
        send_request(tcw_pkg::REQ_PUT, 8'h7F);
        send_request(tcw_pkg::REQ_PUT, 8'h80);
        send_request(tcw_pkg::REQ_CLEAR, 8'h00);
        send_request(tcw_pkg::REQ_PUT, 8'h55);
        send_request(tcw_pkg::REQ_PUT, 8'hAA);
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
        send_request(tcw_pkg::REQ_CLEAR, tcw_pkg::NEWLINE_CODE);
    endtask

    // newline and row wrap on the bottom row, both of which scroll
    task automatic test_bottom_row();
        send_request(tcw_pkg::REQ_CLEAR, rand_text_char());
        repeat (tcw_pkg::ROWS - 1) send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
        repeat (tcw_pkg::COLUMNS) send_request(tcw_pkg::REQ_PUT, rand_text_char());
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
        repeat (tcw_pkg::COLUMNS) send_request(tcw_pkg::REQ_PUT, rand_text_char());
        send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
    endtask

    // lines of random text, mostly short, some wrapping; a little noise
    task automatic test_text_lines(input int n_items);
        int          target;
        int unsigned len;
        int unsigned pick;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) == 0)
                tx_idle_on = $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0)
                rx_idle_on = $urandom_range(0, 1);
            pick = $urandom_range(0, 9);
            len = (pick < 7) ? $urandom_range(0, 12) :
                  (pick < 9) ? $urandom_range(13, 79) : $urandom_range(80, 170);
            repeat (len) begin
                if ($urandom_range(0, 19) == 0)
                    send_request(($urandom_range(0, 7) == 0) ? tcw_pkg::REQ_CLEAR
                                                             : tcw_pkg::REQ_PUT,
                                 8'($urandom_range(0, 255)));
                else
                    send_request(tcw_pkg::REQ_PUT, rand_text_char());
            end
            send_request(tcw_pkg::REQ_PUT, tcw_pkg::NEWLINE_CODE);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'h00;
        i_valid       <= 1'b0;
        i_req_type    <= tcw_pkg::REQ_PUT;
        i_char_code   <= 8'h00;
        col_now       = 0;
        row_now       = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_text_attribute(8'h00);
        test_edge_codes();
        wait_drained();

        set_text_attribute(8'hFF);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_bottom_row();
        wait_drained();

        set_text_attribute(tcw_pkg::ATTR_RESET);
        test_text_lines(PHASE_ITEMS);
        wait_drained();
        repeat (3) begin
            set_text_attribute(8'($urandom_range(0, 255)));
            test_text_lines(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d clears, %0d scrolls), checked %0d cursor results",
                 items_sent, clears_sent, scrolls_predicted, results_checked);
        $display("Attribute at both extremes and random; traffic with and without stalls");
        if (err_count == 0 && cursor_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d errors, %0d results missing", err_count, cursor_expect_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
